@@ design/i2da_pkg.sv @@
// ----------------------------------------------------------------------------
// i2da_pkg
// Shared types, constants and decimal weight functions for the signed
// 32-bit to decimal ASCII converter.
// ----------------------------------------------------------------------------
package i2da_pkg;

   localparam int unsigned VALUE_WIDTH  = 32;
   localparam int unsigned CHAR_WIDTH   = 8;
   localparam int unsigned POS_WIDTH    = 4;
   localparam int unsigned WEIGHT_WIDTH = 34;
   localparam int unsigned MAX_POS      = 9;
   localparam int unsigned QUEUE_DEPTH  = 2;

   localparam logic [CHAR_WIDTH-1:0] DIGIT_ZERO = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] MINUS_SIGN = 8'h2D;

   typedef struct packed {
      logic                   negative;
      logic [VALUE_WIDTH-1:0] magnitude;
      logic [POS_WIDTH-1:0]   top_pos;
   } conv_entry_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_SIGN,
      BACK_DIGIT
   } back_state_type;

   function automatic logic [WEIGHT_WIDTH-1:0] pow10(input logic [POS_WIDTH-1:0] pos);
      logic [WEIGHT_WIDTH-1:0] weight;
      case (pos)
         4'd0:    weight = 34'd1;
         4'd1:    weight = 34'd10;
         4'd2:    weight = 34'd100;
         4'd3:    weight = 34'd1000;
         4'd4:    weight = 34'd10000;
         4'd5:    weight = 34'd100000;
         4'd6:    weight = 34'd1000000;
         4'd7:    weight = 34'd10000000;
         4'd8:    weight = 34'd100000000;
         4'd9:    weight = 34'd1000000000;
         default: weight = 34'd1;
      endcase
      return weight;
   endfunction

   function automatic logic [WEIGHT_WIDTH-1:0] digit_threshold(
      input logic [POS_WIDTH-1:0] pos,
      input logic [POS_WIDTH-1:0] multiple
   );
      logic [WEIGHT_WIDTH-1:0] product;
      product = pow10(pos) * WEIGHT_WIDTH'(multiple);
      return product;
   endfunction

endpackage

@@ design/i2da_front.sv @@
// ----------------------------------------------------------------------------
// i2da_front
// Input stage: holds one accepted value, forms sign and magnitude and
// finds the position of the leading decimal digit before queueing it.
// ----------------------------------------------------------------------------
module i2da_front
   import i2da_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic signed [VALUE_WIDTH-1:0] req_tdata,
   output logic                          push_valid,
   input  logic                          push_full,
   output conv_entry_type                push_entry
);

   logic                   valid_ff;
   logic                   valid_in;
   logic [VALUE_WIDTH-1:0] value_ff;
   logic [VALUE_WIDTH-1:0] value_in;
   logic                   accept;
   logic                   pushed;
   logic                   negative;
   logic [VALUE_WIDTH-1:0] magnitude;
   logic [POS_WIDTH-1:0]   top_pos;

   assign pushed     = valid_ff && !push_full;
   assign req_tready = !valid_ff || !push_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (accept) begin
         valid_in = 1'b1;
         value_in = req_tdata;
      end else if (pushed) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
   end

   always_comb begin
      negative  = value_ff[VALUE_WIDTH-1];
      magnitude = negative ? (VALUE_WIDTH'(0) - value_ff) : value_ff;
      top_pos   = '0;
      for (int i = 1; i <= MAX_POS; i++) begin
         if ({2'b00, magnitude} >= pow10(POS_WIDTH'(i))) begin
            top_pos = top_pos + POS_WIDTH'(1);
         end
      end
   end

   assign push_valid           = valid_ff;
   assign push_entry.negative  = negative;
   assign push_entry.magnitude = magnitude;
   assign push_entry.top_pos   = top_pos;

endmodule

@@ design/i2da_queue.sv @@
// ----------------------------------------------------------------------------
// i2da_queue
// Short first-in first-out queue of classified values between the input
// stage and the character generator.
// ----------------------------------------------------------------------------
module i2da_queue
   import i2da_pkg::*;
#(
   parameter int unsigned Depth = QUEUE_DEPTH
)
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push_valid,
   output logic           push_full,
   input  conv_entry_type push_entry,
   input  logic           pop,
   output logic           pop_valid,
   output conv_entry_type pop_entry
);

   localparam int unsigned PtrWidth   = $clog2(Depth);
   localparam int unsigned CountWidth = $clog2(Depth + 1);

   conv_entry_type          entries_ff [Depth];
   logic [PtrWidth-1:0]     wr_ptr_ff;
   logic [PtrWidth-1:0]     wr_ptr_in;
   logic [PtrWidth-1:0]     rd_ptr_ff;
   logic [PtrWidth-1:0]     rd_ptr_in;
   logic [CountWidth-1:0]   count_ff;
   logic [CountWidth-1:0]   count_in;
   logic                    do_push;
   logic                    do_pop;

   assign push_full = (count_ff == CountWidth'(Depth));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = entries_ff[rd_ptr_ff];
   assign do_push   = push_valid && !push_full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + PtrWidth'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + PtrWidth'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CountWidth'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CountWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ design/i2da_back.sv @@
// ----------------------------------------------------------------------------
// i2da_back
// Character generator: pops one classified value, sends the sign if any, then
// one decimal digit per cycle unless rsp stalls, from the leading position down.
// ----------------------------------------------------------------------------
module i2da_back
   import i2da_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   output logic                  pop,
   input  logic                  pop_valid,
   input  conv_entry_type        pop_entry,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [CHAR_WIDTH-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   back_state_type          state_ff;
   back_state_type          state_in;
   logic [VALUE_WIDTH-1:0]  mag_ff;
   logic [VALUE_WIDTH-1:0]  mag_in;
   logic [POS_WIDTH-1:0]    pos_ff;
   logic [POS_WIDTH-1:0]    pos_in;
   logic                    rsp_tvalid_ff;
   logic                    rsp_tvalid_in;
   logic [CHAR_WIDTH-1:0]   rsp_tdata_ff;
   logic [CHAR_WIDTH-1:0]   rsp_tdata_in;
   logic                    rsp_tlast_ff;
   logic                    rsp_tlast_in;
   logic                    out_ready;
   logic [POS_WIDTH-1:0]    digit;
   logic [WEIGHT_WIDTH-1:0] subtrahend;
   logic [WEIGHT_WIDTH-1:0] threshold;

   assign out_ready = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      digit      = '0;
      subtrahend = '0;
      for (int k = 1; k <= 9; k++) begin
         threshold = digit_threshold(pos_ff, POS_WIDTH'(k));
         if ({2'b00, mag_ff} >= threshold) begin
            digit      = POS_WIDTH'(k);
            subtrahend = threshold;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (pop_valid) begin
               state_in = pop_entry.negative ? BACK_SIGN : BACK_DIGIT;
            end
         end
         BACK_SIGN: begin
            if (out_ready) begin
               state_in = BACK_DIGIT;
            end
         end
         BACK_DIGIT: begin
            if (out_ready && pos_ff == '0) begin
               state_in = BACK_IDLE;
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   always_comb begin
      pop           = 1'b0;
      mag_in        = mag_ff;
      pos_in        = pos_ff;
      rsp_tvalid_in = rsp_tready ? 1'b0 : rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tlast_in  = rsp_tlast_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (pop_valid) begin
               pop    = 1'b1;
               mag_in = pop_entry.magnitude;
               pos_in = pop_entry.top_pos;
            end
         end
         BACK_SIGN: begin
            if (out_ready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = MINUS_SIGN;
               rsp_tlast_in  = 1'b0;
            end
         end
         BACK_DIGIT: begin
            if (out_ready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = DIGIT_ZERO + CHAR_WIDTH'(digit);
               rsp_tlast_in  = (pos_ff == '0);
               mag_in        = mag_ff - subtrahend[VALUE_WIDTH-1:0];
               pos_in        = pos_ff - POS_WIDTH'(1);
            end
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BACK_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      mag_ff       <= mag_in;
      pos_ff       <= pos_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tlast_ff <= rsp_tlast_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

endmodule

@@ design/int32_to_decimal_ascii.sv @@
// ----------------------------------------------------------------------------
// int32_to_decimal_ascii
// Signed 32-bit integer to decimal ASCII text, one character per item.
//
// req channel: one signed 32-bit value per item. rsp channel: its text, most
// significant character first, a leading '-' for negative values, no leading
// zeros, and rsp_tlast set on the final character.
// The input stage holds one value and finds its leading digit position; a
// short queue (QueueDepth entries) decouples it from the character
// generator, which pops a value in its idle state and then sends one
// character per cycle unless rsp stalls it.
// A value passes the input stage register, a queue entry, the generator
// registers and then the output register. The generator finishes the
// characters of one value before it pops the next. A stalled rsp_tready
// holds the output register and the generator; the queue and input stage
// keep taking items until they fill. Reset (synchronous, active high)
// empties the input stage, the queue and the output register.
// ----------------------------------------------------------------------------
module int32_to_decimal_ascii
   import i2da_pkg::*;
#(
   parameter int unsigned QueueDepth = QUEUE_DEPTH
)
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic signed [VALUE_WIDTH-1:0] req_tdata,   // [31:0] value
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [CHAR_WIDTH-1:0]         rsp_tdata,   // [7:0] char_code
   output logic                          rsp_tlast
);

   logic           push_valid;
   logic           push_full;
   conv_entry_type push_entry;
   logic           pop;
   logic           pop_valid;
   conv_entry_type pop_entry;

   i2da_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_full  (push_full),
      .push_entry (push_entry)
   );

   i2da_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_full  (push_full),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry)
   );

   i2da_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ tb/sv/int32_to_decimal_ascii_tb.sv @@
// ----------------------------------------------------------------------------
// int32_to_decimal_ascii_tb
// Self-checking testbench for the signed 32-bit to decimal ASCII converter.
// A directed table covers zero, single digits, powers of ten and both ends of
// the 32-bit range. Random values of every digit count follow. Each accepted
// value is turned into its expected characters and each rsp item is checked
// against the oldest one. Both channels idle at random. One long rsp stall
// backs the converter up, and one pause lets the output drain completely.
// ----------------------------------------------------------------------------
module int32_to_decimal_ascii_tb
   import i2da_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DIRECTED_COUNT = 20;
   localparam int RANDOM_COUNT   = 230;
   localparam int BLOCK_SIZE     = 25;
   localparam int HOLD_CYCLES    = 400;
   localparam int DRAIN_CYCLES   = 20;
   localparam int RESET_CYCLES   = 6;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] code;
      logic                  last;
   } ascii_char_type;

   logic                          clock      = 1'b0;
   logic                          reset      = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic signed [VALUE_WIDTH-1:0] req_tdata  = '0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [CHAR_WIDTH-1:0]         rsp_tdata;
   logic                          rsp_tlast;

   ascii_char_type pending_chars[$];
   string          typed_texts[$];
   int             mismatch_count = 0;
   bit             src_idle_on    = 1'b1;
   bit             sink_idle_on   = 1'b1;
   bit             hold_request   = 1'b0;
   bit             sink_holding   = 1'b0;

   logic [VALUE_WIDTH-1:0] directed_values [DIRECTED_COUNT] = '{
      32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99, 32'd100,
      32'd12345, -32'sd54321, 32'd999999999, 32'd1000000000, -32'sd1000000000,
      32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA,
      -32'sd1999999999
   };

   // empty text: take the expectation from predict_text
   string directed_texts [DIRECTED_COUNT] = '{
      "0", "1", "-1", "9", "-9", "10", "", "", "",
      "", "", "", "", "",
      "2147483647", "-2147483647", "-2147483648", "", "",
      ""
   };

   always #1 clock = ~clock;

   int32_to_decimal_ascii i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   function automatic void predict_text(input logic [VALUE_WIDTH-1:0] value);
      logic [VALUE_WIDTH-1:0] magnitude;
      logic [3:0]             digits [10];
      int                     count;
      ascii_char_type         ch;
      magnitude = value[VALUE_WIDTH-1] ? -value : value;
      count = 0;
      do begin
         digits[count] = 4'(magnitude % 10);
         magnitude     = magnitude / 10;
         count++;
      end while (magnitude != 0);
      if (value[VALUE_WIDTH-1]) begin
         ch.code = MINUS_SIGN;
         ch.last = 1'b0;
         pending_chars.push_back(ch);
      end
      for (int d = count - 1; d >= 0; d--) begin
         ch.code = DIGIT_ZERO + CHAR_WIDTH'(digits[d]);
         ch.last = (d == 0);
         pending_chars.push_back(ch);
      end
   endfunction

   function automatic void expect_text(input string text);
      ascii_char_type ch;
      for (int i = 0; i < text.len(); i++) begin
         ch.code = text[i];
         ch.last = (i == text.len() - 1);
         pending_chars.push_back(ch);
      end
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [VALUE_WIDTH-1:0] random_value();
      int                     roll;
      longint                 limit;
      logic [VALUE_WIDTH-1:0] value;
      roll  = $urandom_range(0, 9);
      limit = 1;
      if (roll < 4) begin
         value = $urandom;
      end else if (roll < 8) begin
         repeat ($urandom_range(1, 10)) limit = limit * 10;
         value = VALUE_WIDTH'(longint'($urandom) % limit);
         if ($urandom_range(0, 1) == 1) value = -value;
      end else if (roll == 8) begin
         repeat ($urandom_range(0, 9)) limit = limit * 10;
         value = VALUE_WIDTH'(limit) - VALUE_WIDTH'($urandom_range(0, 1));
         if ($urandom_range(0, 1) == 1) value = -value;
      end else begin
         case ($urandom_range(0, 3))
            0:       value = 32'h0000_0000;
            1:       value = 32'h7FFF_FFFF;
            2:       value = 32'h8000_0000;
            default: value = 32'hFFFF_FFFF;
         endcase
      end
      return value;
   endfunction

   task automatic send_item(input logic [VALUE_WIDTH-1:0] value, input string text);
      int gap;
      typed_texts.push_back(text);
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      gap = src_idle_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_for_drain();
      while (pending_chars.size() != 0 || typed_texts.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin : monitor
      ascii_char_type want;
      string          text;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            text = typed_texts.pop_front();
            if (text.len() == 0) begin
               predict_text(req_tdata);
            end else begin
               expect_text(text);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_chars.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected item: char %h last %b", $time, rsp_tdata, rsp_tlast);
            end else begin
               want = pending_chars.pop_front();
               if (rsp_tdata !== want.code) begin
                  mismatch_count++;
                  $display("%0t: char mismatch: expected %h actual %h",
                           $time, want.code, rsp_tdata);
               end
               if (rsp_tlast !== want.last) begin
                  mismatch_count++;
                  $display("%0t: last mismatch: expected %b actual %b",
                           $time, want.last, rsp_tlast);
               end
            end
         end
      end
   end

   initial begin : sink
      int stall;
      while (reset) @(posedge clock);
      rsp_tready <= 1'b1;
      forever begin
         repeat ($urandom_range(1, 8)) @(posedge clock);
         if (hold_request) begin
            sink_holding = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_tready <= 1'b1;
            sink_holding = 1'b0;
         end else if (sink_idle_on) begin
            stall = pick_gap();
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   initial begin : source
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         send_item(directed_values[i], directed_texts[i]);
      end
      for (int i = 0; i < RANDOM_COUNT; i++) begin
         if (i % BLOCK_SIZE == 0) begin
            src_idle_on  = ($urandom_range(0, 3) != 0);
            sink_idle_on = ($urandom_range(0, 3) != 0);
         end
         // back up the converter: long rsp stall under back-to-back items
         if (i == 3 * BLOCK_SIZE) begin
            src_idle_on  = 1'b0;
            req_tvalid <= 1'b0;
            hold_request = 1'b1;
            wait (sink_holding);
            hold_request = 1'b0;
         end
         if (i == 5 * BLOCK_SIZE) begin
            req_tvalid <= 1'b0;
            wait_for_drain();
         end
         send_item(random_value(), "");
      end
      req_tvalid <= 1'b0;
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_chars.size() != 0) begin
         mismatch_count++;
         $display("%0t: %0d expected items never arrived", $time, pending_chars.size());
      end
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
